[src/cpa_pkg.sv]
// ----------------------------------------------------------------------------
// cpa_pkg: shared types and constants for the command phase aligner
// Register indexes, reset values, sequencer states and inter-module structs.
// ----------------------------------------------------------------------------
`default_nettype none

package cpa_pkg;

  localparam int unsigned PhaseW  = 8;
  localparam int unsigned MagW    = PhaseW - 1;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned Lanes   = 2;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegPeriod  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCenter  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSafeMin = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSafeMax = 3'd3;
  localparam logic [CfgIdxW-1:0] RegConfirm = 3'd4;

  // Reset values
  localparam logic [PhaseW-1:0] PeriodRst  = 8'd50;
  localparam logic [PhaseW-1:0] CenterRst  = 8'd25;
  localparam logic [PhaseW-1:0] SafeMinRst = 8'd10;
  localparam logic [PhaseW-1:0] SafeMaxRst = 8'd40;
  localparam logic [PhaseW-1:0] ConfirmRst = 8'd3;

  localparam logic [PhaseW-1:0] CountMax = {PhaseW{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_FOLD_L,
    S_FOLD_R,
    S_CHECK0,
    S_SEARCH,
    S_EMIT
  } state_e;

  // Band and modulus settings seen by the candidate evaluator
  typedef struct packed {
    logic [PhaseW-1:0] period;   // already forced to at least one
    logic [PhaseW-1:0] center;
    logic [PhaseW-1:0] safe_min;
    logic [PhaseW-1:0] safe_max;
  } eval_cfg_t;

  // Request to the remainder unit
  typedef struct packed {
    logic              start;
    logic [PhaseW-1:0] dividend;
  } mod_req_t;

  // Status from the remainder unit
  typedef struct packed {
    logic              done;
    logic [PhaseW-1:0] rem;
  } mod_rsp_t;

  // One candidate shift to score
  typedef struct packed {
    logic [Lanes-1:0]         known;
    logic [PhaseW-1:0]        phase_l;
    logic [PhaseW-1:0]        phase_r;
    logic signed [PhaseW-1:0] shift;
  } eval_req_t;

  typedef struct packed {
    logic              valid;
    logic [PhaseW-1:0] cost;
  } eval_rsp_t;

  // Result beat handed to the output register
  typedef struct packed {
    logic                     load;
    logic signed [PhaseW-1:0] shift;
  } emit_t;

endpackage : cpa_pkg

`default_nettype wire

[src/cpa_mod_unit.sv]
// ----------------------------------------------------------------------------
// cpa_mod_unit: iterative remainder unit
// Restoring remainder of an 8-bit phase by the period, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cpa_mod_unit
  import cpa_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mod_req_t          req_i,
  input  wire logic [PhaseW-1:0] divisor_i,
  output mod_rsp_t               rsp_o
);

  localparam int unsigned CntW = $clog2(PhaseW + 1);

  logic              active_q, active_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [PhaseW-1:0] num_q, num_d;
  logic [PhaseW-1:0] rem_q, rem_d;
  logic [PhaseW:0]   trial;

  always_comb begin
    trial    = {rem_q, num_q[PhaseW-1]};
    active_d = active_q;
    cnt_d    = cnt_q;
    num_d    = num_q;
    rem_d    = rem_q;
    if (req_i.start) begin
      active_d = 1'b1;
      cnt_d    = CntW'(PhaseW);
      num_d    = req_i.dividend;
      rem_d    = '0;
    end else if (active_q) begin
      if (cnt_q == '0) begin
        active_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
        num_d = {num_q[PhaseW-2:0], 1'b0};
        if (trial >= {1'b0, divisor_i}) begin
          rem_d = PhaseW'(trial - {1'b0, divisor_i});
        end else begin
          rem_d = trial[PhaseW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = active_q && (cnt_q == '0);
  assign rsp_o.rem  = rem_q;

endmodule : cpa_mod_unit

`default_nettype wire

[src/cpa_eval.sv]
// ----------------------------------------------------------------------------
// cpa_eval: candidate shift evaluator
// Wraps each known phase by the shift, checks the safe band, scores distance.
// ----------------------------------------------------------------------------
`default_nettype none

module cpa_eval
  import cpa_pkg::*;
(
  input  wire eval_cfg_t cfg_i,
  input  wire eval_req_t req_i,
  output eval_rsp_t      rsp_o
);

  localparam int unsigned XW = PhaseW + 2;

  logic signed [XW-1:0] x    [Lanes];
  logic signed [XW-1:0] modv;
  logic signed [XW-1:0] dext;
  logic [PhaseW-1:0]    p    [Lanes];
  logic [PhaseW-1:0]    dev  [Lanes];
  logic [PhaseW-1:0]    ph   [Lanes];
  logic                 ok;
  logic [PhaseW-1:0]    worst;

  always_comb begin
    ph[0] = req_i.phase_l;
    ph[1] = req_i.phase_r;
    modv  = $signed({2'b00, cfg_i.period});
    dext  = $signed({{2{req_i.shift[PhaseW-1]}}, req_i.shift});
    ok    = 1'b1;
    worst = '0;
    for (int i = 0; i < Lanes; i++) begin
      x[i] = $signed({2'b00, ph[i]}) - dext;
      // one correction either way keeps the value in [0, period)
      if (x[i] < 0) begin
        x[i] = x[i] + modv;
      end else if (x[i] >= modv) begin
        x[i] = x[i] - modv;
      end
      p[i] = x[i][PhaseW-1:0];
      if (p[i] >= cfg_i.center) begin
        dev[i] = p[i] - cfg_i.center;
      end else begin
        dev[i] = cfg_i.center - p[i];
      end
      if (req_i.known[i]) begin
        if ((p[i] < cfg_i.safe_min) || (p[i] > cfg_i.safe_max)) begin
          ok = 1'b0;
        end
        if (dev[i] > worst) begin
          worst = dev[i];
        end
      end
    end
  end

  assign rsp_o.valid = ok;
  assign rsp_o.cost  = worst;

endmodule : cpa_eval

`default_nettype wire

[src/cpa_seq.sv]
// ----------------------------------------------------------------------------
// cpa_seq: search sequencer
// Folds both phases, walks candidate shifts, tracks the unsafe-tick count.
// ----------------------------------------------------------------------------
`default_nettype none

module cpa_seq
  import cpa_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [PhaseW-1:0] period_i,
  input  wire logic [PhaseW-1:0] confirm_i,
  input  wire logic              in_valid_i,
  input  wire logic              left_known_i,
  input  wire logic [PhaseW-1:0] left_phase_i,
  input  wire logic              right_known_i,
  input  wire logic [PhaseW-1:0] right_phase_i,
  output logic                   in_stall_o,
  output mod_req_t               mod_req_o,
  input  wire mod_rsp_t          mod_rsp_i,
  output eval_req_t              eval_req_o,
  input  wire eval_rsp_t         eval_rsp_i,
  input  wire logic              out_free_i,
  output emit_t                  emit_o
);

  state_e state_q, state_d;

  logic [Lanes-1:0]         known_q;
  logic [PhaseW-1:0]        ph_r_q;
  logic [PhaseW-1:0]        fold_l_q;
  logic [PhaseW-1:0]        fold_r_q;
  logic [MagW-1:0]          mag_q;
  logic                     neg_q;
  logic                     have_q;
  logic signed [PhaseW-1:0] best_q;
  logic [PhaseW-1:0]        pick_cost_q;
  logic [PhaseW-1:0]        unsafe_q;

  logic                     accept;
  logic [MagW-1:0]          half;
  logic signed [PhaseW-1:0] cand_shift;
  logic                     trivial;
  logic                     take;
  logic                     last;
  logic [PhaseW-1:0]        unsafe_inc;
  logic                     confirmed;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign half       = period_i[PhaseW-1:1];
  assign cand_shift = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
  assign trivial    = (known_q == '0) || eval_rsp_i.valid;
  assign take       = eval_rsp_i.valid && (!have_q || (eval_rsp_i.cost < pick_cost_q));
  assign last       = neg_q && (mag_q == half);
  assign unsafe_inc = (unsafe_q == CountMax) ? unsafe_q : unsafe_q + 1'b1;
  assign confirmed  = unsafe_inc >= confirm_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (accept) state_d = S_FOLD_L;
      S_FOLD_L: if (mod_rsp_i.done) state_d = S_FOLD_R;
      S_FOLD_R: if (mod_rsp_i.done) state_d = S_CHECK0;
      S_CHECK0: begin
        if (trivial || (half == '0)) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: if (last) state_d = S_EMIT;
      S_EMIT:   if (out_free_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall_o         = (state_q != S_IDLE);
    mod_req_o.start    = 1'b0;
    mod_req_o.dividend = left_phase_i;
    eval_req_o.known   = known_q;
    eval_req_o.phase_l = fold_l_q;
    eval_req_o.phase_r = fold_r_q;
    eval_req_o.shift   = '0;
    emit_o.load        = 1'b0;
    emit_o.shift       = '0;
    case (state_q)
      S_IDLE: mod_req_o.start = accept;
      S_FOLD_L: begin
        mod_req_o.start    = mod_rsp_i.done;
        mod_req_o.dividend = ph_r_q;
      end
      S_SEARCH: eval_req_o.shift = cand_shift;
      S_EMIT: begin
        emit_o.load = out_free_i;
        if (have_q && confirmed) begin
          emit_o.shift = best_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      unsafe_q <= '0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_EMIT) && out_free_i) begin
        if (!have_q || confirmed) begin
          unsafe_q <= '0;
        end else begin
          unsafe_q <= unsafe_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      known_q <= {right_known_i, left_known_i};
      ph_r_q  <= right_phase_i;
    end
    if ((state_q == S_FOLD_L) && mod_rsp_i.done) fold_l_q <= mod_rsp_i.rem;
    if ((state_q == S_FOLD_R) && mod_rsp_i.done) fold_r_q <= mod_rsp_i.rem;
    case (state_q)
      S_CHECK0: begin
        have_q <= 1'b0;
        mag_q  <= MagW'(1);
        neg_q  <= 1'b0;
      end
      S_SEARCH: begin
        if (take) begin
          have_q      <= 1'b1;
          best_q      <= cand_shift;
          pick_cost_q <= eval_rsp_i.cost;
        end
        if (neg_q) begin
          mag_q <= mag_q + 1'b1;
        end
        neg_q <= !neg_q;
      end
      default: ;
    endcase
  end

endmodule : cpa_seq

`default_nettype wire

[src/command_phase_aligner.sv]
// ----------------------------------------------------------------------------
// command_phase_aligner: send-time shift search for command phase feedback
// Searches wrap-around shifts that bring the fed-back phases into the safe
// band and issues the best one after enough consecutive unsafe ticks.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel: one beat per tick carries left/right known flags and
//    phases. in_valid_i with in_stall_o low takes the beat; in_stall_o is
//    high from the accept until the result has been moved to the output
//    register.
//  - Output channel: one shift_ms_o beat per input beat, held in an output
//    register until out_stall_i drops. A new input beat may be taken while
//    that result still waits.
//  - Sequence: after the accept, two remainder passes (start plus 8 bit
//    steps) fold the phases, a check step tests the zero shift, the
//    shared evaluator then scores one candidate per cycle, positive before
//    negative at each magnitude up to half the period, and an emit step
//    loads the result once the output register is free. The candidate
//    search is skipped when nothing is known, the zero shift fits or half
//    the period is zero. The sequencer takes no new beat before the
//    current result has entered the output register.
//  - A stalled output holds the sequencer in its final step; the unsafe
//    counter only moves when the result enters the output register.
//  - Reset (rst_ni low, async) loads default settings, clears the unsafe
//    counter, returns the sequencer to idle and empties the output register.
//  - Settings are written through cfg_we_i/cfg_index_i/cfg_wdata_i while
//    no beat is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module command_phase_aligner
  import cpa_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [PhaseW-1:0]    cfg_wdata_i,
  // input beat
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 left_known_i,
  input  wire logic [PhaseW-1:0]    left_phase_i,
  input  wire logic                 right_known_i,
  input  wire logic [PhaseW-1:0]    right_phase_i,
  // output beat
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic signed [PhaseW-1:0]  shift_ms_o
);

  // Settings registers
  logic [PhaseW-1:0] period_q, center_q, safe_min_q, safe_max_q, confirm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= PeriodRst;
      center_q   <= CenterRst;
      safe_min_q <= SafeMinRst;
      safe_max_q <= SafeMaxRst;
      confirm_q  <= ConfirmRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegPeriod:  period_q   <= cfg_wdata_i;
        RegCenter:  center_q   <= cfg_wdata_i;
        RegSafeMin: safe_min_q <= cfg_wdata_i;
        RegSafeMax: safe_max_q <= cfg_wdata_i;
        RegConfirm: confirm_q  <= cfg_wdata_i;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // A zero period acts as a period of one
  logic [PhaseW-1:0] period_eff;
  assign period_eff = (period_q == '0) ? PhaseW'(1) : period_q;

  eval_cfg_t eval_cfg;
  assign eval_cfg.period   = period_eff;
  assign eval_cfg.center   = center_q;
  assign eval_cfg.safe_min = safe_min_q;
  assign eval_cfg.safe_max = safe_max_q;

  mod_req_t  mod_req;
  mod_rsp_t  mod_rsp;
  eval_req_t eval_req;
  eval_rsp_t eval_rsp;
  emit_t     emit;

  // Output register: free when empty or being drained this cycle
  logic                     out_valid_q;
  logic signed [PhaseW-1:0] shift_q;
  logic                     out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  cpa_mod_unit u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mod_req),
    .divisor_i (period_eff),
    .rsp_o     (mod_rsp)
  );

  cpa_eval u_eval (
    .cfg_i (eval_cfg),
    .req_i (eval_req),
    .rsp_o (eval_rsp)
  );

  cpa_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .period_i      (period_eff),
    .confirm_i     (confirm_q),
    .in_valid_i    (in_valid_i),
    .left_known_i  (left_known_i),
    .left_phase_i  (left_phase_i),
    .right_known_i (right_known_i),
    .right_phase_i (right_phase_i),
    .in_stall_o    (in_stall_o),
    .mod_req_o     (mod_req),
    .mod_rsp_i     (mod_rsp),
    .eval_req_o    (eval_req),
    .eval_rsp_i    (eval_rsp),
    .out_free_i    (out_free),
    .emit_o        (emit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.load) begin
      shift_q <= emit.shift;
    end
  end

  assign out_valid_o = out_valid_q;
  assign shift_ms_o  = shift_q;

endmodule : command_phase_aligner

`default_nettype wire

[src/cpa_checker.sv]
// ----------------------------------------------------------------------------
// cpa_checker: port-level checks for the command phase aligner
// Watches the handshake and result range; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cpa_checker
  import cpa_pkg::*;
(
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_stall_o,
  input wire logic                     out_valid_o,
  input wire logic                     out_stall_i,
  input wire logic signed [PhaseW-1:0] shift_ms_o
);

  // Stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(shift_ms_o))
    else $error("stalled result beat changed");

  // Block is busy right after taking a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again without a search in between");

  // No result can appear in the cycle after a beat is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared before the search ran");

  // Shift magnitude never exceeds half of the largest period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> shift_ms_o != -8'sd128)
    else $error("shift out of range");

endmodule : cpa_checker

bind command_phase_aligner cpa_checker u_cpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .shift_ms_o  (shift_ms_o)
);

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for command_phase_aligner
// Offers feedback ticks, predicts the confirmed shift of each one from a
// local copy of the settings and the unsafe counter, and compares every
// shift beat with the oldest prediction under random idling and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench
  import cpa_pkg::*;
();

  localparam int CycleLimit = 1000000;
  localparam int HoldCycles = 600;
  localparam int EndWait    = 300;
  localparam int MaxReports = 10;

  typedef enum {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // Settings copy, unsafe counter and the queue of shifts still due.
  class shift_ledger;
    logic [PhaseW-1:0]        period;
    logic [PhaseW-1:0]        center;
    logic [PhaseW-1:0]        safe_min;
    logic [PhaseW-1:0]        safe_max;
    logic [PhaseW-1:0]        confirm;
    logic [PhaseW-1:0]        unsafe_count;
    logic signed [PhaseW-1:0] pending_shifts[$];
    int                       errors;

    function void reset_state();
      period       = PeriodRst;
      center       = CenterRst;
      safe_min     = SafeMinRst;
      safe_max     = SafeMaxRst;
      confirm      = ConfirmRst;
      unsafe_count = '0;
      errors       = 0;
      pending_shifts.delete();
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [PhaseW-1:0] val);
      case (idx)
        RegPeriod:  period   = val;
        RegCenter:  center   = val;
        RegSafeMin: safe_min = val;
        RegSafeMax: safe_max = val;
        RegConfirm: confirm  = val;
        default: ;
      endcase
    endfunction

    // A zero period behaves as a period of one
    function int modulus();
      return (period == 0) ? 1 : int'(period);
    endfunction

    function int wrap(int v, int m);
      int r;
      r = v % m;
      return (r < 0) ? r + m : r;
    endfunction

    // Shift fits when every known phase lands in the band after wrapping;
    // cost is the worst distance from the center among the known phases.
    function bit shift_fits(bit known[2], int phase[2], int d, output int cost);
      int p;
      int dev;
      cost = 0;
      for (int i = 0; i < 2; i++) begin
        if (known[i]) begin
          p = wrap(phase[i] - d, modulus());
          if (p < int'(safe_min) || p > int'(safe_max)) return 1'b0;
          dev = p - int'(center);
          if (dev < 0) dev = -dev;
          if (dev > cost) cost = dev;
        end
      end
      return 1'b1;
    endfunction

    function int pick_shift(bit known[2], int phase[2]);
      int  best;
      int  low_cost;
      int  cost;
      int  d;
      bit  have;
      best = 0;
      low_cost = 0;
      have = 1'b0;
      if (!known[0] && !known[1]) return 0;
      if (shift_fits(known, phase, 0, cost)) return 0;
      // positive before negative; ties keep the earlier pick
      for (int mag = 1; mag <= modulus() / 2; mag++) begin
        for (int s = 0; s < 2; s++) begin
          d = (s == 0) ? mag : -mag;
          if (shift_fits(known, phase, d, cost) && (!have || cost < low_cost)) begin
            have = 1'b1;
            best = d;
            low_cost = cost;
          end
        end
      end
      return have ? best : 0;
    endfunction

    function void take_tick(bit kl, logic [PhaseW-1:0] pl, bit kr, logic [PhaseW-1:0] pr);
      bit                       known[2];
      int                       phase[2];
      int                       d;
      logic signed [PhaseW-1:0] shift;
      known[0] = kl;
      known[1] = kr;
      phase[0] = int'(pl);
      phase[1] = int'(pr);
      d = pick_shift(known, phase);
      shift = '0;
      if (d == 0) begin
        unsafe_count = '0;
      end else begin
        if (unsafe_count != CountMax) unsafe_count++;
        if (unsafe_count >= confirm) begin
          unsafe_count = '0;
          shift = d[PhaseW-1:0];
        end
      end
      pending_shifts.push_back(shift);
    endfunction

    function void check_shift(logic signed [PhaseW-1:0] got);
      logic signed [PhaseW-1:0] want;
      if (pending_shifts.size() == 0) begin
        errors++;
        if (errors <= MaxReports) $display("shift beat with none pending: got %0d", got);
        return;
      end
      want = pending_shifts.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= MaxReports)
          $display("shift mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CfgIdxW-1:0]       cfg_index_i;
  logic [PhaseW-1:0]        cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     left_known_i;
  logic [PhaseW-1:0]        left_phase_i;
  logic                     right_known_i;
  logic [PhaseW-1:0]        right_phase_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [PhaseW-1:0] shift_ms_o;

  shift_ledger ledger;
  int          sender_idle_pct;
  int          recv_stall_pct;
  bit          hold_req;
  int          hold_left;
  int          cycles;

  command_phase_aligner u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .left_known_i  (left_known_i),
    .left_phase_i  (left_phase_i),
    .right_known_i (right_known_i),
    .right_phase_i (right_phase_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .shift_ms_o    (shift_ms_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Beat monitor: both channels sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) ledger.check_shift(shift_ms_o);
      if (in_valid_i && !in_stall_o)
        ledger.take_tick(left_known_i, left_phase_i, right_known_i, right_phase_i);
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin sender_idle_pct = 80; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin sender_idle_pct = 0;  recv_stall_pct = 80; end
      default:       begin sender_idle_pct = 35; recv_stall_pct = 35; end
    endcase
  endtask

  // Offer one tick after an optional idle gap; returns at the accepting edge
  task automatic send_tick(bit kl, logic [PhaseW-1:0] pl, bit kr, logic [PhaseW-1:0] pr);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    left_known_i  <= kl;
    left_phase_i  <= pl;
    right_known_i <= kr;
    right_phase_i <= pr;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (ledger.pending_shifts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [PhaseW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    ledger.set_reg(idx, val);
  endtask

  task automatic apply_settings(int p, int c, int lo, int hi, int cf);
    wait_drained();
    write_reg(RegPeriod, PhaseW'(p));
    write_reg(RegCenter, PhaseW'(c));
    write_reg(RegSafeMin, PhaseW'(lo));
    write_reg(RegSafeMax, PhaseW'(hi));
    write_reg(RegConfirm, PhaseW'(cf));
  endtask

  // Mostly drifting feedback with a nearby partner phase (so a shift
  // usually exists), some in-band ticks to break runs, some raw noise.
  task automatic random_tick();
    int               m;
    int               lo;
    int               hi;
    int               span;
    int               kind;
    int               base;
    bit               kl;
    bit               kr;
    logic [PhaseW-1:0] pl;
    logic [PhaseW-1:0] pr;
    m = ledger.modulus();
    lo = int'(ledger.safe_min);
    hi = int'(ledger.safe_max);
    span = (hi >= lo) ? hi - lo : 0;
    kind = $urandom_range(99);
    if (kind < 60) begin
      base = $urandom_range(m - 1);
      kl = ($urandom_range(7) != 0);
      kr = !kl || ($urandom_range(7) != 0);
      pl = PhaseW'(base);
      pr = PhaseW'((base + $urandom_range(span)) % m);
    end else if (kind < 75 && hi >= lo) begin
      kl = 1'b1;
      kr = 1'($urandom_range(1));
      pl = PhaseW'(lo + $urandom_range(span));
      pr = PhaseW'(lo + $urandom_range(span));
    end else begin
      kl = 1'($urandom_range(1));
      kr = 1'($urandom_range(1));
      pl = PhaseW'($urandom_range(254));
      pr = PhaseW'($urandom_range(254));
    end
    send_tick(kl, pl, kr, pr);
  endtask

  task automatic run_phase(int items, idle_mode_e mode, bit hold_off, bit mid_drain);
    set_idling(mode);
    if (hold_off) hold_req = 1'b1;
    for (int i = 0; i < items; i++) begin
      if (mid_drain && i == items / 2) wait_drained();
      random_tick();
    end
  endtask

  task automatic random_settings(idle_mode_e mode);
    int p;
    int c;
    int lo;
    int hi;
    int cf;
    p  = ($urandom_range(3) != 0) ? $urandom_range(40, 2) : $urandom_range(255, 2);
    c  = $urandom_range(p - 1);
    lo = $urandom_range(p - 1);
    hi = ($urandom_range(9) != 0) ? $urandom_range(p - 1, lo) : $urandom_range(254);
    cf = ($urandom_range(4) != 0) ? $urandom_range(4, 1) : $urandom_range(255, 1);
    apply_settings(p, c, lo, hi, cf);
    run_phase(60, mode, 1'b0, mode == IDLE_SENDER);
  endtask

  initial begin
    ledger = new();
    ledger.reset_state();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    left_known_i  = 1'b0;
    left_phase_i  = '0;
    right_known_i = 1'b0;
    right_phase_i = '0;
    out_stall_i   = 1'b0;
    hold_req      = 1'b0;
    hold_left     = 0;
    cycles        = 0;
    set_idling(IDLE_NONE);
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset settings: nothing known, in band, single and paired
    // unsafe runs, phases above the period, a run broken by a safe tick.
    send_tick(1'b0, 8'd254, 1'b0, 8'd0);
    send_tick(1'b0, 8'd0, 1'b0, 8'd254);
    send_tick(1'b1, 8'd25, 1'b1, 8'd25);
    repeat (3) send_tick(1'b1, 8'd0, 1'b0, 8'd0);
    repeat (3) send_tick(1'b0, 8'd0, 1'b1, 8'd254);
    send_tick(1'b1, 8'd0, 1'b1, 8'd45);
    send_tick(1'b1, 8'd20, 1'b1, 8'd30);
    send_tick(1'b1, 8'd0, 1'b1, 8'd45);

    // Zero period folds everything to zero
    apply_settings(0, 0, 0, 0, 1);
    send_tick(1'b1, 8'd254, 1'b1, 8'd7);
    send_tick(1'b1, 8'd0, 1'b0, 8'd0);
    // Period one with a band that misses zero: nothing fits
    apply_settings(1, 0, 1, 1, 0);
    send_tick(1'b1, 8'd254, 1'b1, 8'd7);
    send_tick(1'b0, 8'd0, 1'b1, 8'd1);
    // Zero confirm issues at once; a spread wider than the band never fits
    apply_settings(50, 11, 10, 12, 0);
    send_tick(1'b1, 8'd0, 1'b0, 8'd0);
    send_tick(1'b1, 8'd0, 1'b0, 8'd0);
    send_tick(1'b1, 8'd0, 1'b1, 8'd30);
    // Empty band, then a band beyond the period
    apply_settings(50, 25, 40, 10, 1);
    send_tick(1'b1, 8'd0, 1'b1, 8'd5);
    send_tick(1'b1, 8'd254, 1'b0, 8'd0);
    apply_settings(20, 35, 30, 40, 1);
    send_tick(1'b1, 8'd3, 1'b1, 8'd17);
    send_tick(1'b0, 8'd0, 1'b1, 8'd9);

    // Random part. First phase: long result hold-off while ticks keep coming.
    apply_settings(50, 25, 10, 40, 3);
    run_phase(60, IDLE_NONE, 1'b1, 1'b0);
    apply_settings(255, 127, 100, 150, 1);
    run_phase(30, IDLE_SENDER, 1'b0, 1'b0);
    apply_settings(2, 0, 0, 0, 2);
    run_phase(40, IDLE_RECEIVER, 1'b0, 1'b0);
    apply_settings(8, 4, 3, 5, 255);
    run_phase(50, IDLE_BOTH, 1'b0, 1'b0);
    apply_settings(255, 254, 240, 254, 2);
    run_phase(40, IDLE_NONE, 1'b0, 1'b1);
    random_settings(IDLE_SENDER);
    random_settings(IDLE_RECEIVER);
    random_settings(IDLE_BOTH);

    wait_drained();
    repeat (EndWait) @(posedge clk_i);
    if (ledger.pending_shifts.size() != 0) ledger.errors++;
    if (ledger.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
